/* hw/rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the sensor packet deframer
// Frame phase codes, the frame record passed from parser to converter,
// queue sizing and configuration register map.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Frame delimiters.
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h55;

  // Widths of the datapath.
  localparam int unsigned WORD_W = 16;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned OFFS_W = 32;
  localparam int unsigned PROD_W = WORD_W + GAIN_W;
  localparam int unsigned DIFF_W = PROD_W + 1;

  // Queue between the parser and the converter.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port: one word per register, index in paddr[2].
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_GAIN   = 1'b0;
  localparam logic        REG_OFFSET = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 24'd481402;
  localparam logic [OFFS_W-1:0] OFFSET_RESET = 32'd1280573;

  // Parser phases: hunt, eight capture bytes, end byte.
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_OX_HI = 4'd1,
    PH_OX_LO = 4'd2,
    PH_PR_HI = 4'd3,
    PH_PR_LO = 4'd4,
    PH_TE_HI = 4'd5,
    PH_TE_LO = 4'd6,
    PH_DE_HI = 4'd7,
    PH_DE_LO = 4'd8,
    PH_END   = 4'd9
  } phase_e;

  // One complete, well-terminated frame.
  typedef struct packed {
    logic [WORD_W-1:0] oxygen_raw;
    logic [WORD_W-1:0] pressure_val;
    logic [WORD_W-1:0] temperature_raw;
    logic [WORD_W-1:0] depth_val;
  } frame_t;

endpackage

/* hw/rtl/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front: byte-level frame parser
// Hunts for the start byte, assembles four big-endian words and pushes one
// frame record into the queue when the end byte matches.
// ----------------------------------------------------------------------------
module spd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output spd_pkg::frame_t frame_o
);
  import spd_pkg::*;

  phase_e phase_q, phase_d, phase_next;
  logic   beat;
  logic   load_upper, load_ox, load_pr, load_te, load_de, end_ok;

  logic [7:0]        upper_q;
  logic [WORD_W-1:0] ox_q, pr_q, te_q, de_q;
  logic [WORD_W-1:0] word;

  // Stall the whole input while the queue has no room.
  assign in_stall_o = q_full_i;
  assign beat       = in_valid_i & ~q_full_i;
  assign word       = {upper_q, rx_byte_i};

  // Next phase for an accepted beat.
  always_comb begin
    case (phase_q)
      PH_OX_HI: phase_next = PH_OX_LO;
      PH_OX_LO: phase_next = PH_PR_HI;
      PH_PR_HI: phase_next = PH_PR_LO;
      PH_PR_LO: phase_next = PH_TE_HI;
      PH_TE_HI: phase_next = PH_TE_LO;
      PH_TE_LO: phase_next = PH_DE_HI;
      PH_DE_HI: phase_next = PH_DE_LO;
      PH_DE_LO: phase_next = PH_END;
      PH_END:   phase_next = PH_HUNT;
      default:  phase_next = (rx_byte_i == START_BYTE) ? PH_OX_HI : PH_HUNT;
    endcase
    phase_d = beat ? phase_next : phase_q;
  end

  // Capture enables decoded from the current phase.
  always_comb begin
    load_upper = 1'b0;
    load_ox    = 1'b0;
    load_pr    = 1'b0;
    load_te    = 1'b0;
    load_de    = 1'b0;
    end_ok     = 1'b0;
    case (phase_q) inside
      PH_OX_HI, PH_PR_HI, PH_TE_HI, PH_DE_HI: load_upper = beat;
      PH_OX_LO: load_ox = beat;
      PH_PR_LO: load_pr = beat;
      PH_TE_LO: load_te = beat;
      PH_DE_LO: load_de = beat;
      PH_END:   end_ok  = beat & (rx_byte_i == END_BYTE);
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Word registers are only read after a full frame has been captured.
  always_ff @(posedge clk_i) begin
    if (load_upper) upper_q <= rx_byte_i;
    if (load_ox)    ox_q    <= word;
    if (load_pr)    pr_q    <= word;
    if (load_te)    te_q    <= word;
    if (load_de)    de_q    <= word;
  end

  assign push_o                  = end_ok;
  assign frame_o.oxygen_raw      = ox_q;
  assign frame_o.pressure_val    = pr_q;
  assign frame_o.temperature_raw = te_q;
  assign frame_o.depth_val       = de_q;

endmodule

/* hw/rtl/spd_queue.sv */
// ----------------------------------------------------------------------------
// spd_queue: short frame queue
// Decouples the byte parser from the oxygen converter so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module spd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spd_pkg::frame_t frame_i,
  output logic            full_o,
  output logic            valid_o,
  output spd_pkg::frame_t frame_o,
  input  logic            pop_i
);
  import spd_pkg::*;

  frame_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign frame_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= frame_i;
  end

endmodule

/* hw/rtl/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back: oxygen conversion pipeline
// Stage one multiplies the raw count by the gain; the output stage subtracts
// the offset, clamps at zero, saturates and holds the result beat.
// ----------------------------------------------------------------------------
module spd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  spd_pkg::frame_t           frame_i,
  output logic                      pop_o,
  input  logic [spd_pkg::GAIN_W-1:0] gain_i,
  input  logic [spd_pkg::OFFS_W-1:0] offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [spd_pkg::WORD_W-1:0] oxygen_centi_o,
  output logic [spd_pkg::WORD_W-1:0] pressure_word_o,
  output logic [spd_pkg::WORD_W-1:0] temperature_word_o,
  output logic [spd_pkg::WORD_W-1:0] depth_word_o
);
  import spd_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [PROD_W-1:0] s1_prod_q;
  logic [WORD_W-1:0] s1_pr_q, s1_te_q, s1_de_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] ox_q, pr_q, te_q, de_q;

  logic              out_ready, s1_move, s1_free;
  logic [DIFF_W-1:0] diff;
  logic [WORD_W-1:0] ox_conv;

  // Pipeline flow control.
  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign s1_move   = s1_valid_q & out_ready;
  assign s1_free   = ~s1_valid_q | out_ready;
  assign pop_o     = q_valid_i & s1_free;

  always_comb begin
    s1_valid_d  = s1_free ? q_valid_i : s1_valid_q;
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  // Offset subtraction with clamp at zero and saturation at full scale.
  always_comb begin
    diff = {1'b0, s1_prod_q} - DIFF_W'(offset_i);
    if (diff[DIFF_W-1]) begin
      ox_conv = '0;
    end else if (|diff[PROD_W-1:WORD_W+16]) begin
      ox_conv = '1;
    end else begin
      ox_conv = diff[WORD_W+15:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_prod_q <= PROD_W'(frame_i.oxygen_raw) * PROD_W'(gain_i);
      s1_pr_q   <= frame_i.pressure_val;
      s1_te_q   <= frame_i.temperature_raw;
      s1_de_q   <= frame_i.depth_val;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      ox_q <= ox_conv;
      pr_q <= s1_pr_q;
      te_q <= s1_te_q;
      de_q <= s1_de_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign oxygen_centi_o     = ox_q;
  assign pressure_word_o    = pr_q;
  assign temperature_word_o = te_q;
  assign depth_word_o       = de_q;

endmodule

/* hw/rtl/sensor_packet_deframer_core.sv */
// Throughput: one received byte per cycle while the input is not stalled; a frame is ten byte beats.
// Path: after the end byte is taken, the result beat passes the queue write,
// the multiply stage and the output register, and output stall can hold it.
// The input stalls only while the two-entry frame queue is full.
// Reset (asynchronous, active low) returns the parser to hunting, empties
// the queue and pipeline and loads the default gain and offset.
// ----------------------------------------------------------------------------
// sensor_packet_deframer_core: sensor frame deframer top level
// Parser front end, frame queue and oxygen conversion back end, plus the
// configuration registers for oxygen gain and offset.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spd_pkg::WORD_W-1:0]    oxygen_centi_o,
  output logic [spd_pkg::WORD_W-1:0]    pressure_word_o,
  output logic [spd_pkg::WORD_W-1:0]    temperature_word_o,
  output logic [spd_pkg::WORD_W-1:0]    depth_word_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [spd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [spd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import spd_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic [OFFS_W-1:0] offset_q;
  logic              reg_sel, cfg_wr;

  logic   push, q_full, q_valid, pop;
  frame_t push_frame, head_frame;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RESET;
      offset_q <= OFFSET_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_GAIN) begin
        gain_q <= pwdata[GAIN_W-1:0];
      end else begin
        offset_q <= pwdata[OFFS_W-1:0];
      end
    end
  end

  // Register readback.
  always_comb begin
    case (reg_sel)
      REG_GAIN:   prdata = CFG_DATA_W'(gain_q);
      REG_OFFSET: prdata = CFG_DATA_W'(offset_q);
      default:    prdata = '0;
    endcase
  end

  spd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .frame_o    (push_frame)
  );

  spd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .full_o  (q_full),
    .valid_o (q_valid),
    .frame_o (head_frame),
    .pop_i   (pop)
  );

  spd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .frame_i            (head_frame),
    .pop_o              (pop),
    .gain_i             (gain_q),
    .offset_i           (offset_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .oxygen_centi_o     (oxygen_centi_o),
    .pressure_word_o    (pressure_word_o),
    .temperature_word_o (temperature_word_o),
    .depth_word_o       (depth_word_o)
  );

endmodule

/* hw/rtl/spd_checker.sv */
// ----------------------------------------------------------------------------
// spd_checker: port-level checks for the sensor packet deframer
// Watches the top-level ports and flags handshake and register slips.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [spd_pkg::WORD_W-1:0]    oxygen_centi_o,
  input logic [spd_pkg::WORD_W-1:0]    pressure_word_o,
  input logic [spd_pkg::WORD_W-1:0]    temperature_word_o,
  input logic [spd_pkg::WORD_W-1:0]    depth_word_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [spd_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [spd_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [spd_pkg::CFG_DATA_W-1:0] prdata,
  input logic                          pready
);
  import spd_pkg::*;

  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps all of its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> $stable({oxygen_centi_o, pressure_word_o, temperature_word_o, depth_word_o}))
    else $error("result payload changed while stalled");

  // The queue can only back up into the input while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // A gain write is visible to a read of the gain in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_GAIN)
    |=> !(psel && !pwrite && (paddr[2] == REG_GAIN))
        || (prdata == CFG_DATA_W'($past(pwdata[GAIN_W-1:0]))))
    else $error("gain readback mismatch");

endmodule

bind sensor_packet_deframer_core spd_checker u_spd_checker (.*);
